// ----- hdl/wfdp_pkg.sv -----
// Package for the weather frame deframer and parser.
// Beat types, framing constants, status codes and the digit limit table.
// No dependencies.
package wfdp_pkg;

    localparam int unsigned FIELD_SLOTS = 6;
    localparam int unsigned VALUE_W     = 17;

    localparam logic [31:0] HEADER_WORD  = 32'h5555_5524;  // "UUU$"
    localparam logic [31:0] TRAILER_WORD = 32'h2A51_5151;  // "*QQQ"
    localparam logic [7:0]  CHAR_DOT     = 8'h2E;

    localparam logic [2:0] HEX_SLOT    = 3'd5;
    localparam logic [2:0] NEED_FIELDS = 3'd5;

    localparam logic [1:0] STATUS_PARSED   = 2'd0;
    localparam logic [1:0] STATUS_FAILED   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef logic [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  frame_length;
        logic [16:0] temperature_raw;
        logic [16:0] pressure_raw;
        logic [13:0] wind_direction;
        logic [16:0] wind_speed;
        logic [9:0]  supply_millivolts;
        logic [15:0] check_word;
        logic        check_present;
    } t_out_beat;

    // Digit limit of each field; the last one is the hex check word.
    function automatic logic [2:0] max_digits(input logic [2:0] slot);
        logic [2:0] m;
        begin
            case (slot)
                3'd0: m = 3'd5;
                3'd1: m = 3'd5;
                3'd2: m = 3'd4;
                3'd3: m = 3'd5;
                3'd4: m = 3'd3;
                3'd5: m = 3'd4;
                default: m = 3'd0;
            endcase
            return m;
        end
    endfunction

endpackage

// ----- hdl/wfdp_stream_if.sv -----
// Valid/ready stream interface carrying one beat of a given payload type.
// Payload types come from wfdp_pkg.
interface wfdp_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/weather_frame_deframer_parser.sv -----
// Weather frame deframer and parser top level.
// Depends on wfdp_pkg and wfdp_stream_if.
//
// Takes one serial byte per beat and returns at most one result per byte, valid in
// the cycle after that byte is taken; a byte can be taken every cycle while the result
// register is empty or being drained in the same cycle. Header search, the frame byte
// count and the update of the one field accumulator that the byte addresses all settle
// combinationally from the registered state, and the result lands in a single output
// register. After the trailer or an overflow the byte window is cleared, so a new
// header needs four fresh bytes.
module weather_frame_deframer_parser #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wfdp_stream_if.sink           i_rx,
    wfdp_stream_if.source         o_res
);

    localparam int CW = $clog2(BUFFER_BYTES);
    localparam logic [CW-1:0] COUNT_LAST   = CW'(BUFFER_BYTES - 1);
    localparam logic [CW-1:0] COUNT_HEADER = CW'(4);

    logic [31:0]          r_window, n_window;
    logic                 r_in_frame, n_in_frame;
    logic [CW-1:0]        r_count, n_count;
    logic [2:0]           r_field, n_field;
    logic [2:0]           r_digits, n_digits;
    logic                 r_stopped, n_stopped;
    wfdp_pkg::t_value     r_vals [wfdp_pkg::FIELD_SLOTS];
    wfdp_pkg::t_value     n_vals [wfdp_pkg::FIELD_SLOTS];

    logic                 r_out_valid;
    wfdp_pkg::t_out_beat  r_out, n_out;
    logic                 n_emit;

    logic                 accept;
    logic [7:0]           b;
    logic                 hex;
    logic                 is_dec, is_hex_uc, is_hex_lc, is_digit;
    logic [3:0]           dval;
    wfdp_pkg::t_value     acc, acc_next;
    logic [2:0]           lim;
    logic [3:0]           converted;
    logic [31:0]          count_ext;

    assign accept      = i_rx.valid && i_rx.ready;
    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign b           = i_rx.data.rx_byte;

    // digit decode for the current field
    always_comb begin
        hex       = (r_field == wfdp_pkg::HEX_SLOT);
        is_dec    = b inside {[8'h30:8'h39]};
        is_hex_uc = b inside {[8'h41:8'h46]};
        is_hex_lc = b inside {[8'h61:8'h66]};
        is_digit  = is_dec || (hex && (is_hex_uc || is_hex_lc));
        if (is_dec) begin
            dval = b[3:0];
        end else begin
            dval = 4'(b[2:0] + 3'd1) + 4'd8;
        end
        lim = wfdp_pkg::max_digits(r_field);
        if (r_field < 3'(wfdp_pkg::FIELD_SLOTS)) begin
            acc = r_vals[r_field];
        end else begin
            acc = '0;
        end
        if (hex) begin
            acc_next = {acc[wfdp_pkg::VALUE_W-5:0], 4'b0000}
                       + wfdp_pkg::VALUE_W'(dval);
        end else begin
            acc_next = {acc[wfdp_pkg::VALUE_W-4:0], 3'b000}
                       + {acc[wfdp_pkg::VALUE_W-2:0], 1'b0}
                       + wfdp_pkg::VALUE_W'(dval);
        end
    end

    always_comb begin
        n_window   = r_window;
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_field    = r_field;
        n_digits   = r_digits;
        n_stopped  = r_stopped;
        n_vals     = r_vals;
        n_emit     = 1'b0;
        n_out      = r_out;
        converted  = '0;
        count_ext  = '0;

        if (accept) begin
            if (!r_in_frame) begin
                n_window = {r_window[23:0], b};
                if (n_window == wfdp_pkg::HEADER_WORD) begin
                    n_in_frame = 1'b1;
                    n_count    = COUNT_HEADER;
                    n_field    = '0;
                    n_digits   = '0;
                    n_stopped  = 1'b0;
                    for (int i = 0; i < wfdp_pkg::FIELD_SLOTS; i++) begin
                        n_vals[i] = '0;
                    end
                end
            end else begin
                if (r_count < COUNT_LAST) begin
                    n_count  = r_count + CW'(1);
                    n_window = {r_window[23:0], b};
                    // field parser
                    if (r_stopped || r_field >= 3'(wfdp_pkg::FIELD_SLOTS)) begin
                        n_stopped = 1'b1;
                    end else if (is_digit && r_digits < lim) begin
                        n_vals[r_field] = acc_next;
                        n_digits        = r_digits + 3'd1;
                        if (hex && (r_digits + 3'd1) == lim) begin
                            n_stopped = 1'b1;
                        end
                    end else if (!hex && r_digits != '0 && b == wfdp_pkg::CHAR_DOT) begin
                        n_field  = r_field + 3'd1;
                        n_digits = '0;
                    end else begin
                        n_stopped = 1'b1;
                    end
                    if (n_window == wfdp_pkg::TRAILER_WORD) begin
                        n_emit    = 1'b1;
                        converted = {1'b0, n_field} + {3'b000, (n_digits != '0)};
                        count_ext = 32'(n_count);
                        n_out.status = (converted >= {1'b0, wfdp_pkg::NEED_FIELDS})
                                       ? wfdp_pkg::STATUS_PARSED
                                       : wfdp_pkg::STATUS_FAILED;
                        n_out.frame_length      = count_ext[6:0];
                        n_out.temperature_raw   = n_vals[0];
                        n_out.pressure_raw      = n_vals[1];
                        n_out.wind_direction    = n_vals[2][13:0];
                        n_out.wind_speed        = n_vals[3];
                        n_out.supply_millivolts = n_vals[4][9:0];
                        n_out.check_word        = n_vals[5][15:0];
                        n_out.check_present     =
                            (converted >= 4'(wfdp_pkg::FIELD_SLOTS));
                    end
                end else begin
                    n_emit    = 1'b1;
                    count_ext = 32'(r_count);
                    n_out     = '0;
                    n_out.status       = wfdp_pkg::STATUS_OVERFLOW;
                    n_out.frame_length = count_ext[6:0];
                end
                if (n_emit) begin
                    n_in_frame = 1'b0;
                    n_count    = '0;
                    n_window   = '0;
                    n_field    = '0;
                    n_digits   = '0;
                    n_stopped  = 1'b0;
                    for (int i = 0; i < wfdp_pkg::FIELD_SLOTS; i++) begin
                        n_vals[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_field     <= '0;
            r_digits    <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < wfdp_pkg::FIELD_SLOTS; i++) begin
                r_vals[i] <= '0;
            end
        end else begin
            r_window   <= n_window;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_field    <= n_field;
            r_digits   <= n_digits;
            r_stopped  <= n_stopped;
            r_vals     <= n_vals;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_out <= n_out;
        end
    end

endmodule
